// ----- rtl/message_segment_framer_macros.svh -----
// ----------------------------------------------------------------------------
// message_segment_framer_macros: assertion helpers for the segment framer
// Clocked on clk_i, idle while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_SEGMENT_FRAMER_MACROS_SVH
`define MESSAGE_SEGMENT_FRAMER_MACROS_SVH

// Same-cycle implication.
`define MSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/msf_pkg.sv -----
// ----------------------------------------------------------------------------
// msf_pkg: shared types and constants of the message segment framer
// Widths, the payload limit and the request passed from front to back.
// ----------------------------------------------------------------------------
package msf_pkg;

  localparam int unsigned CfgW    = 13;
  localparam int unsigned FillW   = 14;
  localparam int unsigned SizeW   = 24;
  localparam int unsigned CodeW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SegNumW = 8;

  localparam logic [CfgW-1:0] PayloadLimit = CfgW'(8192 - 6);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // One classified input byte, as the back end needs it.
  typedef struct packed {
    logic               overrun;
    logic               header;
    logic               seg_end;
    logic [CodeW-1:0]   code;
    logic [SizeW-1:0]   size;
    logic [SegNumW-1:0] seg_num;
    logic [ByteW-1:0]   data;
  } entry_t;

endpackage

// ----- rtl/message_segment_framer.sv -----
// ----------------------------------------------------------------------------
// message_segment_framer: cuts a byte-wide message into headed segments
// A byte's first result passes the queue slot and then the output register before it is offered.
// Throughput: 1 byte per cycle inside a segment while the output is not stalled; a byte that
// opens a segment is preceded by 6 header bytes, which the back emitter inserts.
// Reset (rst_ni low, async): queue empties, no message open, limit = 8186.
// ----------------------------------------------------------------------------
`include "message_segment_framer_macros.svh"

module message_segment_framer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Payload limit register
  input  logic                      cfg_we_i,
  input  logic [msf_pkg::CfgW-1:0]  cfg_wdata_i,
  // Incoming message bytes
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [47:0]               s_axis_tdata,  // message_code, message_size, payload_byte
  input  logic                      s_axis_tuser,  // message_start
  // Framed segment bytes
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,  // wire_byte
  output logic                      m_axis_tlast,  // segment_end
  output logic [1:0]                m_axis_tuser   // run_last, overrun_flag
);
  import msf_pkg::*;

  logic   q_push, q_push_ready, q_pop, q_valid;
  entry_t q_push_entry, q_head;
  logic   run_last, overrun;

  // Front: track the open message, classify each byte, push a request.
  msf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_start_i   (s_axis_tuser),
    .in_code_i    (s_axis_tdata[15:0]),
    .in_size_i    (s_axis_tdata[39:16]),
    .in_byte_i    (s_axis_tdata[47:40]),
    .push_o       (q_push),
    .push_entry_o (q_push_entry),
    .push_ready_i (q_push_ready)
  );

  // Queue: decouple input stalls from header insertion and output stalls.
  msf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_push_entry),
    .push_ready_o (q_push_ready),
    .pop_i        (q_pop),
    .head_valid_o (q_valid),
    .head_entry_o (q_head)
  );

  // Back: emit header bytes when a segment opens, then the payload byte.
  msf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (q_valid),
    .head_entry_i   (q_head),
    .pop_o          (q_pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_byte_o     (m_axis_tdata),
    .out_seg_end_o  (m_axis_tlast),
    .out_run_last_o (run_last),
    .out_overrun_o  (overrun)
  );

  assign m_axis_tuser = {overrun, run_last};

  // An overrun is a lone result: last of its run, never a segment end.
  `MSF_ASSERT_NOW(a_overrun_alone, m_axis_tvalid && overrun, run_last && !m_axis_tlast, "overrun result not alone")
  // A segment only ends on a payload byte, which closes its run.
  `MSF_ASSERT_NOW(a_seg_end_last, m_axis_tvalid && m_axis_tlast, run_last, "segment end not on payload byte")
  // A request leaves the queue only when one is there.
  `MSF_ASSERT_NOW(a_pop_valid, q_pop, q_valid, "queue popped while empty")
  // Once loaded, a stalled result remains visible.
  `MSF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "stalled result dropped")

endmodule

// ----- rtl/msf_queue.sv -----
// ----------------------------------------------------------------------------
// msf_queue: short request queue between front and back
// Flop-based FIFO; the head entry is visible without a read cycle.
// ----------------------------------------------------------------------------
module msf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  msf_pkg::entry_t push_entry_i,
  output logic            push_ready_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output msf_pkg::entry_t head_entry_o
);
  import msf_pkg::*;

  entry_t            slot_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  count_q;
  logic              do_push, do_pop;

  assign push_ready_o = (count_q != QCntW'(QDepth));
  assign head_valid_o = (count_q != '0);
  assign head_entry_o = slot_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCntW'(1);
      end else if (!do_push && do_pop) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

endmodule

// ----- rtl/msf_front.sv -----
// ----------------------------------------------------------------------------
// msf_front: message tracking and byte classification
// Holds the message state and the payload limit, tags each accepted byte.
// ----------------------------------------------------------------------------
module msf_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [msf_pkg::CfgW-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_start_i,
  input  logic [msf_pkg::CodeW-1:0]  in_code_i,
  input  logic [msf_pkg::SizeW-1:0]  in_size_i,
  input  logic [msf_pkg::ByteW-1:0]  in_byte_i,
  output logic                       push_o,
  output msf_pkg::entry_t            push_entry_o,
  input  logic                       push_ready_i
);
  import msf_pkg::*;

  logic [CfgW-1:0]    limit_cfg_q;
  logic [SizeW-1:0]   remain_q, remain_d, remain_c, remain_dec;
  logic [FillW-1:0]   fill_q, fill_d, fill_c, fill_inc;
  logic [SegNumW-1:0] seg_num_q, seg_num_d, seg_num_c;
  logic [CodeW-1:0]   code_q, code_c;
  logic [SizeW-1:0]   size_q, size_c;
  logic [CfgW-1:0]    limit_c;
  logic               overrun_c, seg_end_c, accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;

  // A start byte takes over the new message before anything else.
  assign code_c    = in_start_i ? in_code_i : code_q;
  assign size_c    = in_start_i ? in_size_i : size_q;
  assign remain_c  = in_start_i ? in_size_i : remain_q;
  assign fill_c    = in_start_i ? '0 : fill_q;
  assign seg_num_c = in_start_i ? SegNumW'(1) : seg_num_q;

  always_comb begin
    if (limit_cfg_q == '0) begin
      limit_c = CfgW'(1);
    end else if (limit_cfg_q > PayloadLimit) begin
      limit_c = PayloadLimit;
    end else begin
      limit_c = limit_cfg_q;
    end
  end

  assign overrun_c  = (remain_c == '0);
  assign remain_dec = remain_c - SizeW'(1);
  assign fill_inc   = fill_c + FillW'(1);
  assign seg_end_c  = !overrun_c &&
                      ((remain_dec == '0) || (fill_inc >= FillW'(limit_c)));

  always_comb begin
    if (overrun_c) begin
      remain_d  = remain_c;
      fill_d    = fill_c;
      seg_num_d = seg_num_c;
    end else begin
      remain_d  = remain_dec;
      fill_d    = seg_end_c ? '0 : fill_inc;
      seg_num_d = seg_end_c ? seg_num_c + SegNumW'(1) : seg_num_c;
    end
  end

  assign push_o               = in_valid_i;
  assign push_entry_o.overrun = overrun_c;
  assign push_entry_o.header  = !overrun_c && (fill_c == '0);
  assign push_entry_o.seg_end = seg_end_c;
  assign push_entry_o.code    = code_c;
  assign push_entry_o.size    = size_c;
  assign push_entry_o.seg_num = seg_num_c;
  assign push_entry_o.data    = in_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_cfg_q <= PayloadLimit;
      remain_q    <= '0;
      fill_q      <= '0;
      seg_num_q   <= SegNumW'(1);
      code_q      <= '0;
      size_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_cfg_q <= cfg_wdata_i;
      end
      if (accept) begin
        remain_q  <= remain_d;
        fill_q    <= fill_d;
        seg_num_q <= seg_num_d;
        code_q    <= code_c;
        size_q    <= size_c;
      end
    end
  end

endmodule

// ----- rtl/msf_back.sv -----
// ----------------------------------------------------------------------------
// msf_back: segment byte emitter
// Expands each queued request into the payload byte, led by header bytes if it opens a segment.
// ----------------------------------------------------------------------------
module msf_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  msf_pkg::entry_t            head_entry_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [msf_pkg::ByteW-1:0]  out_byte_o,
  output logic                       out_seg_end_o,
  output logic                       out_run_last_o,
  output logic                       out_overrun_o
);
  import msf_pkg::*;

  typedef enum logic [2:0] {
    STEP_CODE_HI,
    STEP_CODE_LO,
    STEP_SIZE_HI,
    STEP_SIZE_MID,
    STEP_SIZE_LO,
    STEP_SEG_NUM,
    STEP_PAYLOAD
  } step_e;

  step_e            step_q, cur_step;
  logic             load, last_step, valid_q;
  logic [ByteW-1:0] byte_c, byte_q;
  logic             seg_end_q, run_last_q, overrun_q;

  assign cur_step  = head_entry_i.header ? step_q : STEP_PAYLOAD;
  assign last_step = (cur_step == STEP_PAYLOAD);
  assign load      = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o     = load && last_step;

  always_comb begin
    unique case (cur_step)
      STEP_CODE_HI:  byte_c = head_entry_i.code[15:8];
      STEP_CODE_LO:  byte_c = head_entry_i.code[7:0];
      STEP_SIZE_HI:  byte_c = head_entry_i.size[23:16];
      STEP_SIZE_MID: byte_c = head_entry_i.size[15:8];
      STEP_SIZE_LO:  byte_c = head_entry_i.size[7:0];
      STEP_SEG_NUM:  byte_c = head_entry_i.seg_num;
      STEP_PAYLOAD:  byte_c = head_entry_i.overrun ? '0 : head_entry_i.data;
      default:       byte_c = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= STEP_CODE_HI;
      valid_q    <= 1'b0;
      byte_q     <= '0;
      seg_end_q  <= 1'b0;
      run_last_q <= 1'b0;
      overrun_q  <= 1'b0;
    end else begin
      if (load) begin
        step_q     <= last_step ? STEP_CODE_HI : step_e'(step_q + 3'd1);
        valid_q    <= 1'b1;
        byte_q     <= byte_c;
        seg_end_q  <= last_step && head_entry_i.seg_end;
        run_last_q <= last_step;
        overrun_q  <= last_step && head_entry_i.overrun;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = valid_q;
  assign out_byte_o     = byte_q;
  assign out_seg_end_o  = seg_end_q;
  assign out_run_last_o = run_last_q;
  assign out_overrun_o  = overrun_q;

endmodule
